>>> src/rdct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the reload down-counter timer.
// No dependencies; used by rdct_step and reload_down_counter_timer_unit.
package rdct_pkg;

    localparam int CNT_W    = 24;
    localparam int SLOW_DIV = 8;
    localparam int PRE_W    = $clog2(SLOW_DIV);
    localparam int READ_W   = 24;

    // Control register bit positions.
    localparam int CTRL_EN_BIT   = 0;
    localparam int CTRL_INT_BIT  = 1;
    localparam int CTRL_CLK_BIT  = 2;
    localparam int CTRL_ONE_BIT  = 3;
    localparam int CTRL_FLAG_BIT = 16;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SEL_CTRL    = 2'd0,
        SEL_RELOAD  = 2'd1,
        SEL_CURRENT = 2'd2,
        SEL_ELAPSED = 2'd3
    } t_sel;

    typedef struct packed {
        logic             run_enable;
        logic             irq_enable;
        logic             fast_clock;
        logic             one_shot;
        logic             flag;
        logic [CNT_W-1:0] reload_value;
        logic [CNT_W-1:0] current_value;
        logic [PRE_W-1:0] prescale;
    } t_state;

    typedef struct packed {
        logic [READ_W-1:0] read_data;
        logic              irq_pulse;
        logic              expired;
    } t_result;

endpackage

>>> src/rdct_step.sv
`timescale 1ns / 1ps
// Next-state and result logic for one transaction of the timer.
// Depends on rdct_pkg.
module rdct_step (
    input  rdct_pkg::t_state            i_state,
    input  logic [1:0]                  i_kind,
    input  logic [1:0]                  i_reg_select,
    input  logic [rdct_pkg::READ_W-1:0] i_write_data,
    output rdct_pkg::t_state            o_state,
    output rdct_pkg::t_result           o_result
);

    logic [rdct_pkg::PRE_W:0]   pre_inc;
    logic                       pre_wrap;
    logic                       count_evt;
    logic [rdct_pkg::CNT_W-1:0] cur_dec;
    logic [rdct_pkg::CNT_W-1:0] elapsed;
    logic [rdct_pkg::READ_W-1:0] ctrl_rd;

    always_comb begin
        pre_inc  = {1'b0, i_state.prescale} + 1'b1;
        pre_wrap = (pre_inc >= (rdct_pkg::PRE_W+1)'(rdct_pkg::SLOW_DIV));
        count_evt = i_state.run_enable && (i_state.fast_clock || pre_wrap);
        cur_dec  = i_state.current_value - 1'b1;
        elapsed  = i_state.reload_value - i_state.current_value;

        ctrl_rd = '0;
        ctrl_rd[rdct_pkg::CTRL_EN_BIT]   = i_state.run_enable;
        ctrl_rd[rdct_pkg::CTRL_INT_BIT]  = i_state.irq_enable;
        ctrl_rd[rdct_pkg::CTRL_CLK_BIT]  = i_state.fast_clock;
        ctrl_rd[rdct_pkg::CTRL_ONE_BIT]  = i_state.one_shot;
        ctrl_rd[rdct_pkg::CTRL_FLAG_BIT] = i_state.flag;

        o_state  = i_state;
        o_result = '0;

        case (rdct_pkg::t_kind'(i_kind))
            rdct_pkg::KIND_TICK: begin
                // The prescaler only moves while the divided clock is in use.
                if (i_state.run_enable && !i_state.fast_clock) begin
                    o_state.prescale = pre_wrap ? '0 : pre_inc[rdct_pkg::PRE_W-1:0];
                end
                if (count_evt) begin
                    if (i_state.current_value == '0) begin
                        o_state.current_value = i_state.reload_value;
                    end else begin
                        o_state.current_value = cur_dec;
                        if (cur_dec == '0) begin
                            o_result.expired   = 1'b1;
                            o_result.irq_pulse = i_state.irq_enable;
                            o_state.flag       = 1'b1;
                            if (i_state.one_shot) begin
                                o_state.run_enable = 1'b0;
                            end
                        end
                    end
                end
            end
            rdct_pkg::KIND_READ: begin
                case (rdct_pkg::t_sel'(i_reg_select))
                    rdct_pkg::SEL_CTRL: begin
                        o_result.read_data = ctrl_rd;
                        o_state.flag       = 1'b0;
                    end
                    rdct_pkg::SEL_RELOAD: begin
                        o_result.read_data = rdct_pkg::READ_W'(i_state.reload_value);
                    end
                    rdct_pkg::SEL_CURRENT: begin
                        o_result.read_data = rdct_pkg::READ_W'(i_state.current_value);
                    end
                    default: begin
                        o_result.read_data = rdct_pkg::READ_W'(elapsed);
                    end
                endcase
            end
            rdct_pkg::KIND_WRITE: begin
                case (rdct_pkg::t_sel'(i_reg_select))
                    rdct_pkg::SEL_CTRL: begin
                        o_state.run_enable = i_write_data[rdct_pkg::CTRL_EN_BIT];
                        o_state.irq_enable = i_write_data[rdct_pkg::CTRL_INT_BIT];
                        o_state.fast_clock = i_write_data[rdct_pkg::CTRL_CLK_BIT];
                        o_state.one_shot   = i_write_data[rdct_pkg::CTRL_ONE_BIT];
                    end
                    rdct_pkg::SEL_RELOAD: begin
                        o_state.reload_value = rdct_pkg::CNT_W'(i_write_data);
                    end
                    rdct_pkg::SEL_CURRENT: begin
                        o_state.current_value = '0;
                        o_state.flag          = 1'b0;
                    end
                    default: begin
                        o_state = i_state;
                    end
                endcase
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

>>> src/reload_down_counter_timer_unit.sv
`timescale 1ns / 1ps
// Top level of the reload down-counter timer: handshakes, state and result register.
// Depends on rdct_pkg and rdct_step.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | to unit   | i_valid / o_ready    | i_kind, i_reg_select, i_write_data
//  out     | from unit | o_valid / i_ready    | o_read_data, o_irq_pulse, o_expired
//
// Every accepted transaction updates the timer state at the edge on which it is
// taken and loads its single result into the output register at that same edge,
// so the result is offered on the output channel from the following cycle.
// The unit takes one transaction per clock cycle; the only limit is the output
// register, which must be free or being emptied in the same cycle.
// Reset (synchronous, active low) clears every state bit and the output valid.
// While the output is stalled and full, o_ready is low and the state holds.
module reload_down_counter_timer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_kind,
    input  logic [1:0]                  i_reg_select,
    input  logic [rdct_pkg::READ_W-1:0] i_write_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rdct_pkg::READ_W-1:0] o_read_data,
    output logic                        o_irq_pulse,
    output logic                        o_expired
);

    rdct_pkg::t_state  r_state;
    rdct_pkg::t_state  n_state;
    rdct_pkg::t_result r_result;
    rdct_pkg::t_result n_result;
    logic              r_valid;
    logic              in_take;

    // The output register can take a new result when it is empty or being read.
    assign o_ready = !r_valid || i_ready;
    assign in_take = i_valid && o_ready;

    rdct_step u_step (
        .i_state      (r_state),
        .i_kind       (i_kind),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_state <= n_state;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    // The result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_result.read_data;
    assign o_irq_pulse = r_result.irq_pulse;
    assign o_expired   = r_result.expired;

endmodule

>>> tb/timer_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the reload down-counter timer: predicts every result from the
// accepted transactions and compares it with the unit's output. Depends on rdct_pkg.
module timer_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [1:0]                  i_kind,
    input  logic [1:0]                  i_reg_select,
    input  logic [rdct_pkg::READ_W-1:0] i_write_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [rdct_pkg::READ_W-1:0] i_read_data,
    input  logic                        i_irq_pulse,
    input  logic                        i_expired,
    output int                          o_mismatch_count,
    output int                          o_pending_count
);
    import rdct_pkg::*;

    t_state  timer_model;
    t_result expected_results[$];
    int      mismatch_total = 0;
    int      pending_total  = 0;

    assign o_mismatch_count = mismatch_total;
    assign o_pending_count  = pending_total;

    // Applies one transaction to the timer model and returns the result it gives.
    function automatic t_result predict_access(logic [1:0] kind, logic [1:0] sel,
                                               logic [READ_W-1:0] data);
        t_result res;
        logic    count_now;
        res       = '0;
        count_now = 1'b0;
        case (t_kind'(kind))
            KIND_TICK: begin
                if (timer_model.run_enable) begin
                    if (timer_model.fast_clock) begin
                        count_now = 1'b1;
                    end else if (int'(timer_model.prescale) + 1 >= SLOW_DIV) begin
                        timer_model.prescale = '0;
                        count_now = 1'b1;
                    end else begin
                        timer_model.prescale = timer_model.prescale + 1'b1;
                    end
                end
                if (count_now) begin
                    if (timer_model.current_value == '0) begin
                        timer_model.current_value = timer_model.reload_value;
                    end else begin
                        timer_model.current_value = timer_model.current_value - 1'b1;
                        if (timer_model.current_value == '0) begin
                            res.expired      = 1'b1;
                            res.irq_pulse    = timer_model.irq_enable;
                            timer_model.flag = 1'b1;
                            if (timer_model.one_shot) begin
                                timer_model.run_enable = 1'b0;
                            end
                        end
                    end
                end
            end
            KIND_READ: begin
                case (t_sel'(sel))
                    SEL_CTRL: begin
                        res.read_data[CTRL_EN_BIT]   = timer_model.run_enable;
                        res.read_data[CTRL_INT_BIT]  = timer_model.irq_enable;
                        res.read_data[CTRL_CLK_BIT]  = timer_model.fast_clock;
                        res.read_data[CTRL_ONE_BIT]  = timer_model.one_shot;
                        res.read_data[CTRL_FLAG_BIT] = timer_model.flag;
                        timer_model.flag = 1'b0;
                    end
                    SEL_RELOAD:  res.read_data = timer_model.reload_value;
                    SEL_CURRENT: res.read_data = timer_model.current_value;
                    default: begin
                        res.read_data = timer_model.reload_value - timer_model.current_value;
                    end
                endcase
            end
            KIND_WRITE: begin
                case (t_sel'(sel))
                    SEL_CTRL: begin
                        timer_model.run_enable = data[CTRL_EN_BIT];
                        timer_model.irq_enable = data[CTRL_INT_BIT];
                        timer_model.fast_clock = data[CTRL_CLK_BIT];
                        timer_model.one_shot   = data[CTRL_ONE_BIT];
                    end
                    SEL_RELOAD: timer_model.reload_value = data[CNT_W-1:0];
                    SEL_CURRENT: begin
                        timer_model.current_value = '0;
                        timer_model.flag          = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_result(string what, t_result want, t_result seen);
        mismatch_total++;
        if (mismatch_total <= 10) begin
            $display("%0t ns: %s: expected read_data=%h irq=%b expired=%b, got read_data=%h irq=%b expired=%b",
                     $time, what, want.read_data, want.irq_pulse, want.expired,
                     seen.read_data, seen.irq_pulse, seen.expired);
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            timer_model = '0;
            expected_results.delete();
            pending_total <= 0;
        end else begin
            // The result leaving now belongs to an earlier transaction, so pop first.
            if (i_out_valid && i_out_ready) begin
                seen.read_data = i_read_data;
                seen.irq_pulse = i_irq_pulse;
                seen.expired   = i_expired;
                if (expected_results.size() == 0) begin
                    report_result("result with nothing outstanding", '0, seen);
                end else begin
                    want = expected_results.pop_front();
                    if (want.read_data !== seen.read_data || want.irq_pulse !== seen.irq_pulse ||
                        want.expired !== seen.expired) begin
                        report_result("result differs", want, seen);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_access(i_kind, i_reg_select, i_write_data));
            end
            pending_total <= expected_results.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the timer testbench: clock, reset, transaction stimulus and the verdict.
// Depends on rdct_pkg, reload_down_counter_timer_unit and timer_result_checker.
module tb_top;
    import rdct_pkg::*;

    // Control register values, built from the bit positions in the package.
    localparam logic [READ_W-1:0] CTRL_EN       = READ_W'(1) << CTRL_EN_BIT;
    localparam logic [READ_W-1:0] CTRL_INT      = READ_W'(1) << CTRL_INT_BIT;
    localparam logic [READ_W-1:0] CTRL_FAST     = READ_W'(1) << CTRL_CLK_BIT;
    localparam logic [READ_W-1:0] CTRL_ONE_SHOT = READ_W'(1) << CTRL_ONE_BIT;
    localparam logic [READ_W-1:0] ALL_ONES      = '1;
    localparam int                RANDOM_ITEMS  = 500;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [1:0]        in_kind   = KIND_TICK;
    logic [1:0]        in_sel    = SEL_CTRL;
    logic [READ_W-1:0] in_data   = '0;
    logic              out_ready = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic [READ_W-1:0] out_read_data;
    logic              out_irq_pulse;
    logic              out_expired;

    // Shared between the sender and the receiver: a stretch with no idling on either
    // side, and a request for the receiver to hold off for a long while.
    bit no_gaps          = 1'b0;
    bit hold_off_request = 1'b0;

    int mismatch_count;
    int pending_count;

    // 2 ns period: high for 1 ns, low for 1 ns.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    reload_down_counter_timer_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_kind      (in_kind),
        .i_reg_select(in_sel),
        .i_write_data(in_data),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_read_data (out_read_data),
        .o_irq_pulse (out_irq_pulse),
        .o_expired   (out_expired)
    );

    // The checker watches both channels from beside the unit, so the top only has
    // to produce transactions and read back the failure count at the end.
    timer_result_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_kind          (in_kind),
        .i_reg_select    (in_sel),
        .i_write_data    (in_data),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_read_data     (out_read_data),
        .i_irq_pulse     (out_irq_pulse),
        .i_expired       (out_expired),
        .o_mismatch_count(mismatch_count),
        .o_pending_count (pending_count)
    );

    // Offers one transaction. Inputs change only at the falling edge; the task returns
    // just after the rising edge at which the unit took the transaction. An idle gap
    // of random length may come first, so that gaps fall on every phase of the timer.
    task automatic send_access(input t_kind kind, input t_sel sel,
                               input logic [READ_W-1:0] data);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 20) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_sel   <= sel;
        in_data  <= data;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    // Chooses a random transaction. Ticks dominate so that the counter actually runs
    // down; reload values are mostly small so that expiries, reloads and one-shot
    // stops happen often, with the odd full-width value and the odd zero reload.
    task automatic pick_random_access(output t_kind kind, output t_sel sel,
                                      output logic [READ_W-1:0] data);
        int roll;
        roll = $urandom_range(99);
        sel  = t_sel'($urandom_range(3));
        data = READ_W'($urandom);
        if (roll < 60) begin
            kind = KIND_TICK;
        end else if (roll < 75) begin
            kind = KIND_READ;
        end else if (roll < 97) begin
            kind = KIND_WRITE;
            roll = $urandom_range(99);
            if (roll < 35) begin
                // Mostly leave the timer running and one-shot mode off.
                sel = SEL_CTRL;
                data[CTRL_EN_BIT]  = ($urandom_range(3) != 0);
                data[CTRL_ONE_BIT] = ($urandom_range(3) == 0);
            end else if (roll < 75) begin
                sel = SEL_RELOAD;
                if ($urandom_range(9) < 8) begin
                    data = READ_W'($urandom_range(12));
                end
            end else if (roll < 90) begin
                sel = SEL_CURRENT;
            end else begin
                sel = SEL_ELAPSED;
            end
        end else begin
            kind = KIND_NONE;
        end
    endtask

    // The receiver. It normally drops ready in about one cycle in five, never during
    // the gap-free stretch, and on request keeps ready low until its hold_left count
    // runs out, while the sender keeps offering, so that the output register fills and
    // the unit has to refuse input.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left        = 60;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= no_gaps || ($urandom_range(99) >= 20);
            end
        end
    end

    initial begin : stimulus
        t_kind             kind;
        t_sel              sel;
        logic [READ_W-1:0] data;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Every register straight after reset, the elapsed count included.
        send_access(KIND_READ, SEL_CTRL, '0);
        send_access(KIND_READ, SEL_RELOAD, '0);
        send_access(KIND_READ, SEL_CURRENT, '0);
        send_access(KIND_READ, SEL_ELAPSED, '0);

        // Fast clock with interrupts: the first tick loads the reload value, the
        // count then runs to zero with an interrupt, and the next tick reloads.
        send_access(KIND_WRITE, SEL_RELOAD, READ_W'(3));
        send_access(KIND_WRITE, SEL_CTRL, CTRL_EN | CTRL_INT | CTRL_FAST);
        repeat (5) send_access(KIND_TICK, SEL_CTRL, '0);

        // The control read shows the count flag and clears it; a second read must not.
        send_access(KIND_READ, SEL_CTRL, '0);
        send_access(KIND_READ, SEL_CTRL, '0);

        // Writing the current value ignores its data and clears counter and flag;
        // an elapsed write and an unused transaction kind change nothing.
        send_access(KIND_WRITE, SEL_CURRENT, ALL_ONES);
        send_access(KIND_WRITE, SEL_ELAPSED, ALL_ONES);
        send_access(KIND_NONE, SEL_ELAPSED, ALL_ONES);

        // All control bits set, one-shot among them: the timer stops itself on
        // expiry, and the tick after that does nothing.
        send_access(KIND_WRITE, SEL_CTRL, ALL_ONES);
        repeat (5) send_access(KIND_TICK, SEL_CTRL, ALL_ONES);

        // Divided clock and the widest reload; elapsed then reads the whole reload value.
        send_access(KIND_WRITE, SEL_CTRL, CTRL_EN);
        send_access(KIND_WRITE, SEL_RELOAD, ALL_ONES);
        send_access(KIND_READ, SEL_ELAPSED, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps = (n >= 200 && n < 300);
            if (n == 100 || n == 350) begin
                hold_off_request = 1'b1;
            end
            pick_random_access(kind, sel, data);
            send_access(kind, sel, data);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain every outstanding result, then keep the clock running so that any stray
        // result would still be caught.
        while (pending_count != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // A run that hangs on a handshake, or never drains, ends here as a failure.
    initial begin : watchdog
        #200000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
src/rdct_pkg.sv
src/rdct_step.sv
src/reload_down_counter_timer_unit.sv
tb/timer_result_checker.sv
tb/tb_top.sv
